/* src/pfc_pkg.sv */
// Shared widths, status codes and the table entry layout of the per-flow rate meter.
// No dependencies; the interfaces and the meter unit import this package.
package pfc_pkg;

    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int TIME_W      = 48;
    localparam int MIN_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int RATE_W      = 36;
    // Octets to kbit/s with 8 fraction bits: times 8, times 256, over 1000 ms scaling
    // cancels against milliseconds, leaving a left shift by 11.
    localparam int FRAC_SHIFT  = 11;
    localparam int DIVIDEND_W  = COUNT_W + FRAC_SHIFT;
    localparam int DIV_STEP_W  = $clog2(DIVIDEND_W);

    localparam logic [MIN_W-1:0]  MIN_INTERVAL_RESET = 16'd200;
    localparam logic [RATE_W-1:0] RATE_MAX           = {RATE_W{1'b1}};

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_FULL = 2'd1;
    localparam status_t STATUS_SOON = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]  key_addr;
        logic [PORT_W-1:0]  key_port;
        logic [COUNT_W-1:0] prev_in;
        logic [COUNT_W-1:0] prev_out;
        logic [TIME_W-1:0]  prev_time;
    } entry_t;

endpackage

/* src/pfc_if.sv */
// Valid/ready channel interfaces of the per-flow rate meter: sample, result, configuration.
// Depends on pfc_pkg for the field widths and the status type.
interface pfc_item_if;
    import pfc_pkg::*;

    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  ip_addr;
    logic [PORT_W-1:0]  port_id;
    logic [COUNT_W-1:0] in_count;
    logic [COUNT_W-1:0] out_count;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, ip_addr, port_id, in_count, out_count, now_ms,
                    input ready);
    modport sink   (input valid, ip_addr, port_id, in_count, out_count, now_ms,
                    output ready);
endinterface

interface pfc_result_if;
    import pfc_pkg::*;

    logic              valid;
    logic              ready;
    status_t           status;
    logic [RATE_W-1:0] rate_in;
    logic [RATE_W-1:0] rate_out;

    modport source (output valid, status, rate_in, rate_out, input ready);
    modport sink   (input valid, status, rate_in, rate_out, output ready);
endinterface

interface pfc_cfg_if;
    import pfc_pkg::*;

    logic             valid;
    logic             ready;
    logic [MIN_W-1:0] min_interval_ms;

    modport source (output valid, min_interval_ms, input ready);
    modport sink   (input valid, min_interval_ms, output ready);
endinterface

/* src/pfc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module pfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/per_flow_counter_rate_meter_unit.sv */
// Per-flow counter rate meter: flow table search, new-flow insert and rate divide.
// A result follows the one-entry-per-cycle table scan and, for a sample that is not refused
// and has nonzero elapsed time, the 43-step radix-2 divider; a new sample is accepted
// only once the result has been taken.
// Reset (rst_n, asynchronous, active low) empties the flow table and loads 200 ms as the
// minimum interval. Depends on pfc_pkg, the interfaces in pfc_if and the pfc_ram memory.
module per_flow_counter_rate_meter_unit #(
    parameter int ENTRIES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    pfc_cfg_if.sink       cfg,
    pfc_item_if.sink      item,
    pfc_result_if.source  result
);
    import pfc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MISS   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    // Control registers.
    logic [2:0]       state_reg, state_next;
    logic [MIN_W-1:0] min_interval_reg, min_interval_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             cmp_valid_reg, cmp_valid_next;

    // Payload registers.
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic                  new_entry_reg, new_entry_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [PORT_W-1:0]     port_reg, port_next;
    logic [COUNT_W-1:0]    cur_in_reg, cur_in_next;
    logic [COUNT_W-1:0]    cur_out_reg, cur_out_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [COUNT_W-1:0]    prev_in_reg, prev_in_next;
    logic [COUNT_W-1:0]    prev_out_reg, prev_out_next;
    logic [TIME_W-1:0]     prev_time_reg, prev_time_next;
    logic [TIME_W-1:0]     dt_reg, dt_next;
    logic [TIME_W-1:0]     rem_in_reg, rem_in_next;
    logic [TIME_W-1:0]     rem_out_reg, rem_out_next;
    logic [DIVIDEND_W-1:0] quo_in_reg, quo_in_next;
    logic [DIVIDEND_W-1:0] quo_out_reg, quo_out_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    status_t               status_reg, status_next;
    logic [RATE_W-1:0]     rate_in_reg, rate_in_next;
    logic [RATE_W-1:0]     rate_out_reg, rate_out_next;

    // Table memory.
    entry_t ram_rd_data;
    entry_t ram_wr_data;
    logic   ram_wr_en;

    // Datapath helpers.
    logic              key_match;
    logic              scan_last;
    logic [TIME_W:0]   time_diff;
    logic              time_back;
    logic [TIME_W-1:0] dt;
    logic              too_short;
    logic [COUNT_W-1:0] in_diff;
    logic [COUNT_W-1:0] out_diff;
    logic [TIME_W-1:0]  div_rem_in, div_rem_out;
    logic               div_bit_in, div_bit_out;

    // One restoring division step: shift in the next dividend bit and subtract the
    // elapsed time when it fits. The partial remainder always stays below the divisor.
    function automatic logic [TIME_W:0] div_step(input logic [TIME_W-1:0] rem,
                                                  input logic              next_bit,
                                                  input logic [TIME_W-1:0] divisor);
        logic [TIME_W:0]   shifted;
        logic [TIME_W+1:0] trial;
        logic              fits;
        shifted = {rem, next_bit};
        trial   = {1'b0, shifted} - {2'b00, divisor};
        fits    = !trial[TIME_W+1];
        div_step = fits ? {1'b1, trial[TIME_W-1:0]} : {1'b0, shifted[TIME_W-1:0]};
    endfunction

    // A quotient that does not fit in the rate field is clamped to all ones.
    function automatic logic [RATE_W-1:0] sat_rate(input logic [DIVIDEND_W-1:0] q);
        sat_rate = (q[DIVIDEND_W-1:RATE_W] != '0) ? RATE_MAX : q[RATE_W-1:0];
    endfunction

    pfc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (hit_idx_reg),
        .wr_data (ram_wr_data),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_data)
    );

    // The stored sample is always the key plus the prev registers; by the time the write
    // happens they hold either the fresh entry (zero counters) or the new sample.
    assign ram_wr_data = '{key_addr:  addr_reg,
                           key_port:  port_reg,
                           prev_in:   prev_in_reg,
                           prev_out:  prev_out_reg,
                           prev_time: prev_time_reg};
    assign ram_wr_en   = (state_reg == S_WRITE);

    // The read data in a search cycle belongs to the entry addressed in the previous cycle.
    assign key_match = cmp_valid_reg && (ram_rd_data.key_addr == addr_reg)
                       && (ram_rd_data.key_port == port_reg);
    assign scan_last = (CNT_W'(cmp_idx_reg) == (count_reg - CNT_W'(1)));

    // Elapsed time with borrow, so a clock that went backwards is seen directly.
    assign time_diff = {1'b0, now_reg} - {1'b0, prev_time_reg};
    assign time_back = time_diff[TIME_W];
    assign dt        = time_diff[TIME_W-1:0];
    assign too_short = (dt < TIME_W'(min_interval_reg));

    // Counter deltas wrap modulo 2^32 by construction.
    assign in_diff  = cur_in_reg - prev_in_reg;
    assign out_diff = cur_out_reg - prev_out_reg;

    // Two divide steps, one per lane, run against the same elapsed time.
    assign {div_bit_in, div_rem_in} =
        div_step(rem_in_reg, quo_in_reg[DIVIDEND_W-1], dt_reg);
    assign {div_bit_out, div_rem_out} =
        div_step(rem_out_reg, quo_out_reg[DIVIDEND_W-1], dt_reg);

    // Channel outputs.
    assign cfg.ready       = 1'b1;
    assign item.ready      = (state_reg == S_IDLE);
    assign result.valid    = (state_reg == S_OUT);
    assign result.status   = status_reg;
    assign result.rate_in  = rate_in_reg;
    assign result.rate_out = rate_out_reg;

    always_comb
    begin
        state_next        = state_reg;
        min_interval_next = min_interval_reg;
        count_next        = count_reg;
        cmp_valid_next    = cmp_valid_reg;
        rd_idx_next       = rd_idx_reg;
        cmp_idx_next      = cmp_idx_reg;
        hit_idx_next      = hit_idx_reg;
        new_entry_next    = new_entry_reg;
        addr_next         = addr_reg;
        port_next         = port_reg;
        cur_in_next       = cur_in_reg;
        cur_out_next      = cur_out_reg;
        now_next          = now_reg;
        prev_in_next      = prev_in_reg;
        prev_out_next     = prev_out_reg;
        prev_time_next    = prev_time_reg;
        dt_next           = dt_reg;
        rem_in_next       = rem_in_reg;
        rem_out_next      = rem_out_reg;
        quo_in_next       = quo_in_reg;
        quo_out_next      = quo_out_reg;
        step_next         = step_reg;
        status_next       = status_reg;
        rate_in_next      = rate_in_reg;
        rate_out_next     = rate_out_reg;

        // The user sends configuration transactions only while idle; not enforced here.
        if (cfg.valid)
        begin
            min_interval_next = cfg.min_interval_ms;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    addr_next      = item.ip_addr;
                    port_next      = item.port_id;
                    cur_in_next    = item.in_count;
                    cur_out_next   = item.out_count;
                    now_next       = item.now_ms;
                    rd_idx_next    = '0;
                    cmp_valid_next = 1'b0;
                    new_entry_next = 1'b0;
                    state_next     = (count_reg == '0) ? S_MISS : S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                // Issue the next read while comparing the previous entry.
                rd_idx_next    = rd_idx_reg + IDX_W'(1);
                cmp_idx_next   = rd_idx_reg;
                cmp_valid_next = 1'b1;
                if (key_match)
                begin
                    hit_idx_next   = cmp_idx_reg;
                    prev_in_next   = ram_rd_data.prev_in;
                    prev_out_next  = ram_rd_data.prev_out;
                    prev_time_next = ram_rd_data.prev_time;
                    cmp_valid_next = 1'b0;
                    state_next     = S_CHECK;
                end
                else if (cmp_valid_reg && scan_last)
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = S_MISS;
                end
            end

            S_MISS:
            begin
                if (count_reg >= CNT_W'(ENTRIES))
                begin
                    status_next   = STATUS_FULL;
                    rate_in_next  = '0;
                    rate_out_next = '0;
                    state_next    = S_OUT;
                end
                else
                begin
                    // A new flow starts with zero counters at the current time.
                    hit_idx_next   = IDX_W'(count_reg);
                    count_next     = count_reg + CNT_W'(1);
                    new_entry_next = 1'b1;
                    prev_in_next   = '0;
                    prev_out_next  = '0;
                    prev_time_next = now_reg;
                    state_next     = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (time_back || too_short)
                begin
                    // Nothing is updated, but a freshly created entry must still be stored.
                    status_next   = STATUS_SOON;
                    rate_in_next  = '0;
                    rate_out_next = '0;
                    state_next    = new_entry_reg ? S_WRITE : S_OUT;
                end
                else
                begin
                    status_next    = STATUS_OK;
                    prev_in_next   = cur_in_reg;
                    prev_out_next  = cur_out_reg;
                    prev_time_next = now_reg;
                    if (dt == '0)
                    begin
                        // Zero elapsed time saturates both rates; skip the divider.
                        quo_in_next  = '1;
                        quo_out_next = '1;
                        state_next   = S_WRITE;
                    end
                    else
                    begin
                        dt_next      = dt;
                        rem_in_next  = '0;
                        rem_out_next = '0;
                        quo_in_next  = {in_diff, {FRAC_SHIFT{1'b0}}};
                        quo_out_next = {out_diff, {FRAC_SHIFT{1'b0}}};
                        step_next    = DIV_STEP_W'(DIVIDEND_W - 1);
                        state_next   = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                // Dividend bits shift out at the top while quotient bits shift in below.
                rem_in_next  = div_rem_in;
                rem_out_next = div_rem_out;
                quo_in_next  = {quo_in_reg[DIVIDEND_W-2:0], div_bit_in};
                quo_out_next = {quo_out_reg[DIVIDEND_W-2:0], div_bit_out};
                step_next    = step_reg - DIV_STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                if (status_reg == STATUS_OK)
                begin
                    rate_in_next  = sat_rate(quo_in_reg);
                    rate_out_next = sat_rate(quo_out_reg);
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (result.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            min_interval_reg <= MIN_INTERVAL_RESET;
            count_reg        <= '0;
            cmp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            min_interval_reg <= min_interval_next;
            count_reg        <= count_next;
            cmp_valid_reg    <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_idx_reg   <= hit_idx_next;
        new_entry_reg <= new_entry_next;
        addr_reg      <= addr_next;
        port_reg      <= port_next;
        cur_in_reg    <= cur_in_next;
        cur_out_reg   <= cur_out_next;
        now_reg       <= now_next;
        prev_in_reg   <= prev_in_next;
        prev_out_reg  <= prev_out_next;
        prev_time_reg <= prev_time_next;
        dt_reg        <= dt_next;
        rem_in_reg    <= rem_in_next;
        rem_out_reg   <= rem_out_next;
        quo_in_reg    <= quo_in_next;
        quo_out_reg   <= quo_out_next;
        step_reg      <= step_next;
        status_reg    <= status_next;
        rate_in_reg   <= rate_in_next;
        rate_out_reg  <= rate_out_next;
    end

endmodule
